// ----- rtl/modexp_pkg.sv -----
`default_nettype none

package modexp_pkg;

    localparam int ModWidth             = 31;
    localparam int BaseWidth            = 63;
    localparam int ExpWidth             = 31;
    localparam int ExponentWidthDefault = 31;
    localparam int CntWidth             = $clog2(BaseWidth + 1);

    localparam logic [ModWidth-1:0] ModulusReset = 31'd1000000007;

    typedef enum logic
    {
        OpReduce,
        OpMul
    } op_t;

    // request to the shared shift-add unit
    typedef struct packed
    {
        logic                 start;
        op_t                  op;
        logic [BaseWidth-1:0] mpl;
        logic [ModWidth-1:0]  addend;
    } unit_cmd_t;

    typedef struct packed
    {
        logic                done;
        logic [ModWidth-1:0] result;
    } unit_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/modular_exponentiation.sv -----
// Flow: the base is first reduced mod the modulus, then one modular product per set
//   exponent bit and one squaring per bit below the top set bit; a zero modulus
//   skips the reduction and the products and goes straight to the finish state.
// Requests: one at a time, the next taken once the result is raised; a held result
//   delays the finish.
// Reset: rst_n asynchronous, active low; clears control and loads modulus 1000000007.
`default_nettype none

module modular_exponentiation
#(
    parameter int EXPONENT_WIDTH = modexp_pkg::ExponentWidthDefault
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output      logic                              cfg_ready,
    input  wire logic [modexp_pkg::ModWidth-1:0]   modulus,
    input  wire logic                              in_valid,
    output      logic                              in_stall,
    input  wire logic [modexp_pkg::BaseWidth-1:0]  base,
    input  wire logic [modexp_pkg::ExpWidth-1:0]   exponent,
    output      logic                              out_valid,
    input  wire logic                              out_stall,
    output      logic [modexp_pkg::ModWidth-1:0]   power_mod
);

    localparam int MW = modexp_pkg::ModWidth;
    localparam int BW = modexp_pkg::BaseWidth;
    localparam int EW = modexp_pkg::ExpWidth;

    localparam logic [EW-1:0] ExpMask = (EXPONENT_WIDTH >= EW) ? {EW{1'b1}} :
        EW'((64'd1 << EXPONENT_WIDTH) - 64'd1);

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_REDUCE,
        S_MUL_ACC,
        S_MUL_SQ,
        S_FINISH
    } state_t;

    state_t              state_reg;
    logic [MW-1:0]       modulus_reg;
    logic [EW-1:0]       exp_reg;
    logic [MW-1:0]       acc_reg;
    logic [MW-1:0]       sq_reg;
    logic                out_valid_reg;
    logic [MW-1:0]       power_mod_reg;

    modexp_pkg::unit_cmd_t cmd;
    modexp_pkg::unit_rsp_t rsp;

    logic          accept;
    logic [MW-1:0] sq_cur;
    logic [EW-1:0] exp_view;
    logic          do_acc;
    logic          do_sq;
    logic          finish;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign power_mod = power_mod_reg;

    // latest square: straight from the unit in the cycle it completes
    assign sq_cur = (state_reg == S_REDUCE || state_reg == S_MUL_SQ) ? rsp.result : sq_reg;

    // next step decision on the remaining exponent bits
    always_comb
    begin
        exp_view = exp_reg;
        if (state_reg == S_MUL_SQ || state_reg == S_MUL_ACC)
        begin
            exp_view = exp_reg >> 1;
        end
        do_acc = 1'b0;
        do_sq  = 1'b0;
        finish = 1'b0;
        if (state_reg == S_MUL_ACC)
        begin
            // bit just consumed; square only if higher bits remain
            if (exp_view == '0)
            begin
                finish = 1'b1;
            end
            else
            begin
                do_sq = 1'b1;
            end
        end
        else if (exp_view == '0)
        begin
            finish = 1'b1;
        end
        else if (exp_view[0])
        begin
            do_acc = 1'b1;
        end
        else
        begin
            do_sq = 1'b1;
        end
    end

    always_comb
    begin
        cmd.start  = 1'b0;
        cmd.op     = modexp_pkg::OpMul;
        cmd.mpl    = {sq_cur, {(BW-MW){1'b0}}};
        cmd.addend = sq_cur;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && modulus_reg != '0)
                begin
                    cmd.start = 1'b1;
                    cmd.op    = modexp_pkg::OpReduce;
                    cmd.mpl   = base;
                end
            end
            S_REDUCE, S_MUL_ACC, S_MUL_SQ:
            begin
                if (rsp.done && !finish)
                begin
                    cmd.start = 1'b1;
                    if (do_acc)
                    begin
                        cmd.mpl = {acc_reg, {(BW-MW){1'b0}}};
                    end
                end
            end
            default:
            begin
                cmd.start = 1'b0;
            end
        endcase
    end

    modexp_mulmod u_mulmod
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .modulus (modulus_reg),
        .cmd     (cmd),
        .rsp     (rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            modulus_reg   <= modexp_pkg::ModulusReset;
            exp_reg       <= '0;
            acc_reg       <= '0;
            sq_reg        <= '0;
            out_valid_reg <= 1'b0;
            power_mod_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                modulus_reg <= modulus;
            end
            // the finish state loads its own result below
            if (out_valid_reg && !out_stall && state_reg != S_FINISH)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        exp_reg <= exponent & ExpMask;
                        // modulus of one or zero gives 0 whatever the exponent
                        acc_reg <= (modulus_reg == MW'(1) || modulus_reg == '0) ?
                                   '0 : MW'(1);
                        if (modulus_reg == '0)
                        begin
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            state_reg <= S_REDUCE;
                        end
                    end
                end
                S_REDUCE, S_MUL_ACC, S_MUL_SQ:
                begin
                    if (rsp.done)
                    begin
                        if (state_reg == S_MUL_ACC)
                        begin
                            acc_reg <= rsp.result;
                        end
                        else
                        begin
                            sq_reg <= rsp.result;
                        end
                        if (state_reg == S_MUL_SQ)
                        begin
                            exp_reg <= exp_reg >> 1;
                        end
                        if (finish)
                        begin
                            state_reg <= S_FINISH;
                        end
                        else if (do_acc)
                        begin
                            state_reg <= S_MUL_ACC;
                        end
                        else
                        begin
                            state_reg <= S_MUL_SQ;
                        end
                    end
                end
                S_FINISH:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        power_mod_reg <= acc_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/modexp_mulmod.sv -----
`default_nettype none

// Shift-add modular unit, one multiplier bit per cycle, MSB first.
// OpReduce: result = mpl mod modulus (63 steps).
// OpMul:    result = mpl[62:32] * addend mod modulus (31 steps).
module modexp_mulmod
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic [modexp_pkg::ModWidth-1:0]  modulus,
    input  wire modexp_pkg::unit_cmd_t            cmd,
    output modexp_pkg::unit_rsp_t                 rsp
);

    localparam int MW = modexp_pkg::ModWidth;
    localparam int BW = modexp_pkg::BaseWidth;
    localparam int CW = modexp_pkg::CntWidth;

    logic                busy_reg;
    logic                done_reg;
    logic [CW-1:0]       cnt_reg;
    logic [BW-1:0]       mpl_reg;
    logic [MW-1:0]       addend_reg;
    modexp_pkg::op_t     op_reg;
    logic [MW-1:0]       r_reg;
    logic [MW-1:0]       r_next;

    logic [MW+1:0] x;
    logic [MW+1:0] t;
    logic [MW+1:0] m1;
    logic [MW+1:0] m2;
    logic [MW+1:0] t_red;

    // r < m and x < m (or x is one bit), so 2r + x < 3m: at most two subtractions
    always_comb
    begin
        x = '0;
        if (op_reg == modexp_pkg::OpReduce)
        begin
            x[0] = mpl_reg[BW-1];
        end
        else if (mpl_reg[BW-1])
        begin
            x = {2'b00, addend_reg};
        end
        t  = {1'b0, r_reg, 1'b0} + x;
        m1 = {2'b00, modulus};
        m2 = {1'b0, modulus, 1'b0};
        if (t >= m2)
        begin
            t_red = t - m2;
        end
        else if (t >= m1)
        begin
            t_red = t - m1;
        end
        else
        begin
            t_red = t;
        end
        r_next = t_red[MW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= (cmd.op == modexp_pkg::OpReduce) ? CW'(BW) : CW'(MW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            r_reg      <= '0;
            mpl_reg    <= cmd.mpl;
            addend_reg <= cmd.addend;
            op_reg     <= cmd.op;
        end
        else if (busy_reg)
        begin
            r_reg   <= r_next;
            mpl_reg <= {mpl_reg[BW-2:0], 1'b0};
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = r_reg;

endmodule

`default_nettype wire

// ----- rtl/modexp_checker.sv -----
`default_nettype none

module modexp_checker
(
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_stall,
    input wire logic                              out_valid,
    input wire logic                              out_stall,
    input wire logic [modexp_pkg::ModWidth-1:0]   power_mod
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(power_mod))
        else $error("result dropped or changed under stall");

    // one request at a time: busy straight after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again while busy");

    // a result appears only at the end of an item's work
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without a request in progress");

    // no result in the cycle after an accept
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result too early");

endmodule

bind modular_exponentiation modexp_checker u_modexp_checker (.*);

`default_nettype wire
